// File: rtl/fir_pkg.sv
// Package: coefficient table, state encoding and control struct for the FIR filter.
package fir_pkg;

	localparam int DEF_TAPS       = 24;
	localparam int DEF_COEF_WIDTH = 16;
	localparam int SAMPLE_W       = 16;
	localparam int TABLE_LEN      = 24;

	localparam logic signed [15:0] LP_TABLE_Q15 [TABLE_LEN] = '{
		16'sd0,    -16'sd18,  -16'sd60,  -16'sd81,  16'sd0,    16'sd264,
		16'sd766,  16'sd1497, 16'sd2377, 16'sd3263, 16'sd3985, 16'sd4391,
		16'sd4391, 16'sd3985, 16'sd3263, 16'sd2377, 16'sd1497, 16'sd766,
		16'sd264,  16'sd0,    -16'sd81,  -16'sd60,  -16'sd18,  16'sd0
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND
	} fir_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic done;
	} fir_ctrl_t;

	function automatic logic signed [31:0] coef_at(input int idx, input int cw);
		logic signed [31:0] q;
		if (idx >= TABLE_LEN) begin
			return 32'sd0;
		end
		q = 32'(LP_TABLE_Q15[idx]);
		if (cw >= 16) begin
			return q <<< (cw - 16);
		end
		return (q + (32'sd1 <<< (15 - cw))) >>> (16 - cw);
	endfunction

endpackage

// File: rtl/fir_ctrl.sv
// Sequencer: accepts a sample, steps the shared MAC over all taps, then drains and rounds.
module fir_ctrl #(
	parameter int TAPS  = 24,
	parameter int TAP_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_free,
	output logic               ready,
	output fir_pkg::fir_ctrl_t ctl,
	output logic [TAP_W-1:0]   tap_q
);
	import fir_pkg::*;

	fir_state_t state_q;
	fir_state_t state_nxt;
	logic       last_tap;

	assign last_tap = (tap_q == TAP_W'(TAPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (ctl.load) begin
			tap_q <= '0;
		end else if (ctl.step && !last_tap) begin
			tap_q <= tap_q + TAP_W'(1);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_MAC;
			end
			ST_MAC: begin
				if (last_tap) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_ROUND;
			end
			ST_ROUND: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ready    = 1'b0;
		ctl      = '0;
		unique case (state_q)
			ST_IDLE: begin
				ready    = 1'b1;
				ctl.load = in_valid;
			end
			ST_MAC: begin
				ctl.step = 1'b1;
			end
			ST_DRAIN: begin
				ctl = '0;
			end
			ST_ROUND: begin
				ctl.done = out_free;
			end
			default: ctl = '0;
		endcase
	end

endmodule

// File: rtl/fir_taps.sv
// Sample window: shifts in a new sample, then rotates once per tap to feed the MAC.
module fir_taps #(
	parameter int TAPS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic                 step,
	input  logic signed [15:0]   sample,
	output logic signed [15:0]   head
);
	import fir_pkg::*;

	logic signed [SAMPLE_W-1:0] win_q [TAPS];

	assign head = win_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) win_q[i] <= '0;
		end else if (load) begin
			for (int i = 0; i < TAPS - 1; i++) win_q[i] <= win_q[i + 1];
			win_q[TAPS - 1] <= sample;
		end else if (step) begin
			for (int i = 0; i < TAPS - 1; i++) win_q[i] <= win_q[i + 1];
			win_q[TAPS - 1] <= win_q[0];
		end
	end

endmodule

// File: rtl/fir_mac.sv
// Shared multiply-accumulate with rounding and saturation of the final sum.
module fir_mac #(
	parameter int TAPS       = 24,
	parameter int COEF_WIDTH = 16,
	parameter int TAP_W      = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fir_pkg::fir_ctrl_t ctl,
	input  logic [TAP_W-1:0]   tap,
	input  logic signed [15:0] head,
	output logic signed [15:0] result,
	output logic               clip
);
	import fir_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEF_WIDTH;
	localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
	localparam int FRAC   = COEF_WIDTH - 1;
	localparam int YW     = ACC_W + 1 - FRAC;
	localparam logic signed [ACC_W:0] RND_HALF =
		{{(ACC_W + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};

	logic signed [COEF_WIDTH-1:0] coef;
	logic signed [31:0]           coef_full;
	logic signed [PROD_W-1:0]     prod_s1;
	logic                         prod_v_s1;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [ACC_W:0]        rnd;
	logic signed [YW-1:0]         y;

	assign coef_full = coef_at(int'(tap), COEF_WIDTH);
	assign coef      = coef_full[COEF_WIDTH-1:0];

	always_ff @(posedge clk) begin
		prod_s1 <= head * coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
		end else begin
			prod_v_s1 <= ctl.step;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= '0;
		end else if (prod_v_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	always_comb begin
		rnd = (ACC_W + 1)'(acc_q) + RND_HALF;
		y   = rnd[ACC_W:FRAC];
		if (y > YW'(32767)) begin
			result = 16'sh7fff;
			clip   = 1'b1;
		end else if (y < YW'(-32768)) begin
			result = 16'sh8000;
			clip   = 1'b1;
		end else begin
			result = y[15:0];
			clip   = 1'b0;
		end
	end

endmodule

// File: rtl/fir_filter_24_tap.sv
// Top level: direct-form FIR low-pass filter with one shared multiply-accumulate.
//
//  channel | dir | signals                         | payload
//  s_*     | in  | s_tvalid s_tready s_tdata       | sample request
//  m_*     | out | m_tvalid m_tready m_tdata m_tuser | filtered request, clip flag
//
// Each item makes one multiply per tap on the single shared multiplier,
// then passes through the drain state and the rounding state.
// s_tready is high only while the sequencer is idle, so samples do not overlap.
// A finished result sits in the output register; the next sample is taken
// while it waits, and rounding holds until the output register frees.
// arst_n clears the sample window to zero and empties the output register.
module fir_filter_24_tap #(
	parameter int TAPS       = fir_pkg::DEF_TAPS,
	parameter int COEF_WIDTH = fir_pkg::DEF_COEF_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] filtered_sample
	output logic [0:0]  m_tuser    // [0] clipped
);
	import fir_pkg::*;

	localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

	fir_ctrl_t           ctl;
	logic [TAP_W-1:0]    tap;
	logic signed [15:0]  head;
	logic signed [15:0]  result;
	logic                clip;
	logic                out_free;
	logic                out_valid_q;
	logic [15:0]         out_data_q;
	logic                out_clip_q;

	assign out_free = !out_valid_q || m_tready;

	fir_ctrl #(
		.TAPS  (TAPS),
		.TAP_W (TAP_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.ready    (s_tready),
		.ctl      (ctl),
		.tap_q    (tap)
	);

	fir_taps #(
		.TAPS (TAPS)
	) u_taps (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ctl.load),
		.step   (ctl.step),
		.sample ($signed(s_tdata)),
		.head   (head)
	);

	fir_mac #(
		.TAPS       (TAPS),
		.COEF_WIDTH (COEF_WIDTH),
		.TAP_W      (TAP_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.tap    (tap),
		.head   (head),
		.result (result),
		.clip   (clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.done) begin
			out_data_q <= result;
			out_clip_q <= clip;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_clip_q;

endmodule

// File: rtl/fir_checker.sv
// Port checker for the FIR filter, bound to the top level.
module fir_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an accepted request");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
		else $error("result appeared one cycle after accept");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
		else $error("clip flag set on an unsaturated value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind fir_filter_24_tap fir_checker u_fir_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: test/tb_fir_filter_24_tap.sv
// Testbench for the 24-tap FIR low-pass filter: streamed samples, predicted and checked outputs.
`timescale 1ns / 100ps

module tb_fir_filter_24_tap;

	import fir_pkg::*;

	localparam int WIN = 24;
	localparam int FRAC = 15;

	typedef struct {
		logic signed [15:0] filtered;
		logic               clipped;
	} lowpass_out_t;

	typedef enum int {
		BURST_RANDOM,
		BURST_EXTREME,
		BURST_OVERFLOW,
		BURST_SMALL,
		BURST_CONSTANT,
		BURST_OVERFLOW_LONG
	} burst_kind_t;

	class lowpass_tracker;
		logic signed [15:0] sample_window [WIN];
		lowpass_out_t       pending_outputs [$];
		int                 errors;
		int                 checked;
		int                 sat_high;
		int                 sat_low;

		function new();
			foreach (sample_window[i]) sample_window[i] = '0;
			errors = 0;
			checked = 0;
			sat_high = 0;
			sat_low = 0;
		endfunction

		function void take_sample(logic signed [15:0] x);
			longint       acc;
			longint       y;
			lowpass_out_t r;
			for (int i = 0; i < WIN - 1; i++) sample_window[i] = sample_window[i + 1];
			sample_window[WIN - 1] = x;
			acc = 0;
			for (int i = 0; i < WIN; i++) begin
				acc += longint'(LP_TABLE_Q15[i]) * longint'(sample_window[i]);
			end
			y = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
			r.clipped = 1'b0;
			if (y > 32767) begin
				y = 32767;
				r.clipped = 1'b1;
			end else if (y < -32768) begin
				y = -32768;
				r.clipped = 1'b1;
			end
			r.filtered = 16'(y);
			pending_outputs.push_back(r);
		endfunction

		function void check_output(logic [15:0] data, logic clip);
			lowpass_out_t e;
			if (pending_outputs.size() == 0) begin
				$display("%0t: output %0d clip %0b with none expected", $time,
					$signed(data), clip);
				errors++;
				return;
			end
			e = pending_outputs.pop_front();
			checked++;
			if (e.clipped) begin
				if (e.filtered > 0) sat_high++;
				else sat_low++;
			end
			if (data !== e.filtered) begin
				$display("%0t: filtered_sample expected %0d actual %0d", $time,
					e.filtered, $signed(data));
				errors++;
			end
			if (clip !== e.clipped) begin
				$display("%0t: clipped expected %0b actual %0b", $time, e.clipped, clip);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_outputs.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;

	lowpass_tracker tracker;
	int             idle_pct = 0;
	int             stall_pct = 0;
	int             sent = 0;

	fir_filter_24_tap i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_output(m_tdata, m_tuser[0]);
		end
		m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	task automatic send_sample(input logic signed [15:0] x);
		if (idle_pct != 0) begin
			while ($urandom_range(99) < idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			if ($urandom_range(19) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 60)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= x;
		do @(posedge clk); while (!s_tready);
		tracker.take_sample(x);
		sent++;
	endtask

	// drive sign-matched full-scale samples so that one window saturates
	function automatic logic signed [15:0] overflow_sample(int k, bit neg, int jitter);
		logic signed [15:0] c;
		c = LP_TABLE_Q15[k % WIN];
		if (c == 0) return 16'($urandom);
		if ((c < 0) ^ neg) return 16'(-32768 + jitter);
		return 16'(32767 - jitter);
	endfunction

	task automatic run_burst();
		burst_kind_t        kind;
		int                 len;
		int                 base;
		bit                 neg;
		logic signed [15:0] x;
		kind = burst_kind_t'($urandom_range(0, 5));
		len = $urandom_range(1, 40);
		base = $urandom;
		neg = $urandom_range(0, 1);
		if (kind == BURST_OVERFLOW || kind == BURST_OVERFLOW_LONG) begin
			len = $urandom_range(24, 48);
		end
		for (int k = 0; k < len; k++) begin
			case (kind)
				BURST_RANDOM: begin
					x = 16'($urandom);
				end
				BURST_EXTREME: begin
					case ($urandom_range(0, 4))
						0: x = 16'sd32767;
						1: x = -16'sd32768;
						2: x = 16'sd0;
						3: x = 16'sd1;
						default: x = -16'sd1;
					endcase
				end
				BURST_SMALL: begin
					x = 16'(int'($urandom_range(0, 63)) - 32);
				end
				BURST_CONSTANT: begin
					x = 16'(base);
				end
				default: begin
					x = overflow_sample(k, neg, $urandom_range(0, 200));
				end
			endcase
			send_sample(x);
		end
	endtask

	initial begin
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < WIN; k++) send_sample(overflow_sample(k, 1'b0, 0));
		send_sample(16'sd1);
		send_sample(-16'sd1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 77;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 77;
				end
				default: begin
					idle_pct = 38;
					stall_pct = 38;
				end
			endcase
			while (sent < 26 + (phase + 1) * 470) run_burst();
		end

		s_tvalid <= 1'b0;
		stall_pct = 0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Streamed %0d samples through four handshake phases; %0d outputs checked.",
			sent, tracker.checked);
		$display("Saturated outputs: %0d high, %0d low; %0d mismatches.",
			tracker.sat_high, tracker.sat_low, tracker.errors);
		if (tracker.errors == 0 && tracker.outstanding() == 0) begin
			$display("PASS fir_filter_24_tap");
		end else begin
			$display("FAIL fir_filter_24_tap");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Run timed out with %0d outputs outstanding.", tracker.outstanding());
		$display("FAIL fir_filter_24_tap");
		$finish;
	end

endmodule
